>>> sv/nearest_order_neighbor_search_core_defines.svh
// ----------------------------------------------------------------------------
// nearest order neighbor search core - assertion macros
// shared concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef NEAREST_ORDER_NEIGHBOR_SEARCH_CORE_DEFINES_SVH
`define NEAREST_ORDER_NEIGHBOR_SEARCH_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// assertion on an explicit clock and active-low reset
`define NONS_ASSERT_CLK(lbl, clk_i, rst_n_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) \
		else $error(msg);

// assertion on the block clock and reset
`define NONS_ASSERT(lbl, prop, msg) \
	`NONS_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`else

`define NONS_ASSERT_CLK(lbl, clk_i, rst_n_i, prop, msg)
`define NONS_ASSERT(lbl, prop, msg)

`endif

`endif

>>> sv/nons_pkg.sv
// ----------------------------------------------------------------------------
// nons_pkg
// types and fixed widths of the nearest order neighbor search core
// ----------------------------------------------------------------------------
package nons_pkg;

	localparam int unsigned KEY_W       = 32;
	localparam int unsigned MODE_W      = 2;
	localparam int unsigned NODE_IDX_W  = 10;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned OUT_TDATA_W = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_NEXT   = 2'd2,
		MODE_PREV   = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND    = 2'd0,
		ST_FALLBACK = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SCAN   = 2'd1,
		S_DRAIN  = 2'd2,
		S_FINISH = 2'd3
	} state_t;

endpackage

>>> sv/nearest_order_neighbor_search_core.sv
// ----------------------------------------------------------------------------
// nearest order neighbor search core
// keeps a table of signed order keys and answers next / previous queries
// ----------------------------------------------------------------------------
// The core holds up to MAX_ENTRIES signed 32-bit keys in one synchronous
// memory, in append order. A clear or append transaction gives no result;
// appends past capacity are dropped. A next (previous) query returns the
// index of the smallest (largest) key strictly above (below) the query key,
// lowest index on ties, status found; if nothing qualifies it returns the
// last (first) index with status fallback, and on an empty table index 0
// with status empty. A query walks the table through the single memory
// read port, one key per cycle, and holds the core until its result is
// loaded into the output register (an empty table skips the walk); the
// input side takes one transaction at a time. The result sits in an output
// register, so a clear or append can be taken while the previous query
// result still waits on m_tready.
// ----------------------------------------------------------------------------
`include "nearest_order_neighbor_search_core_defines.svh"

module nearest_order_neighbor_search_core #(
	parameter int unsigned MAX_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] order_key
	input  logic [1:0]  s_tuser,   // [1:0] mode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] node_index, [15:10] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	// table address and entry count widths
	localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned NIW = nons_pkg::NODE_IDX_W;
	localparam int unsigned XW  = AW + NIW;
	localparam int unsigned OTW = nons_pkg::OUT_TDATA_W;
	localparam int unsigned KW  = nons_pkg::KEY_W;

	// key memory
	logic signed [KW-1:0] key_mem [MAX_ENTRIES];

	// control state
	nons_pkg::state_t  state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     rd_ptr_q;
	logic              rd_vld_s1;
	logic              found_q;
	logic              m_tvalid_q;

	// payload registers
	nons_pkg::mode_t      mode_q;
	logic signed [KW-1:0] qkey_q;
	logic signed [KW-1:0] best_key_q;
	logic [AW-1:0]        best_idx_q;
	logic [AW-1:0]        rd_idx_s1;
	logic signed [KW-1:0] rd_data_s1;
	logic [NIW-1:0]       node_q;
	nons_pkg::status_t    status_q;

	// combinational
	nons_pkg::mode_t      in_mode;
	logic                 in_acc;
	logic                 in_query;
	logic                 mem_we;
	logic [CW-1:0]        cnt_m1;
	logic                 scan_last;
	logic                 out_free;
	logic                 out_load;
	logic                 take;
	logic [XW-1:0]        res_idx_x;
	logic [AW-1:0]        res_idx;
	nons_pkg::status_t    res_status;

	assign in_mode  = nons_pkg::mode_t'(s_tuser);
	assign in_acc   = s_tvalid && s_tready;
	assign in_query = (in_mode == nons_pkg::MODE_NEXT) || (in_mode == nons_pkg::MODE_PREV);
	// appends beyond capacity are dropped
	assign mem_we   = in_acc && (in_mode == nons_pkg::MODE_APPEND)
		&& (count_q < CW'(MAX_ENTRIES));
	assign cnt_m1    = count_q - CW'(1);
	assign scan_last = (rd_ptr_q == cnt_m1[AW-1:0]);
	assign out_free  = !m_tvalid_q || m_tready;

	// sequencer: idle, walk the table, let the last read land, hand off result
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			nons_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && in_query) begin
					state_d = (count_q == '0) ? nons_pkg::S_FINISH : nons_pkg::S_SCAN;
				end
			end
			nons_pkg::S_SCAN: begin
				if (scan_last) begin
					state_d = nons_pkg::S_DRAIN;
				end
			end
			nons_pkg::S_DRAIN: begin
				state_d = nons_pkg::S_FINISH;
			end
			nons_pkg::S_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = nons_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nons_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nons_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// memory: one write port for appends, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[count_q[AW-1:0]] <= $signed(s_tdata);
		end
		rd_data_s1 <= key_mem[rd_ptr_q];
		rd_idx_s1  <= rd_ptr_q;
	end

	// candidate test on the key that just came out of memory
	always_comb begin
		if (mode_q == nons_pkg::MODE_NEXT) begin
			take = (rd_data_s1 > qkey_q) && (!found_q || (rd_data_s1 < best_key_q));
		end else begin
			take = (rd_data_s1 < qkey_q) && (!found_q || (rd_data_s1 > best_key_q));
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_ptr_q   <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// table fill level
			if (in_acc && (in_mode == nons_pkg::MODE_CLEAR)) begin
				count_q <= '0;
			end else if (mem_we) begin
				count_q <= count_q + CW'(1);
			end
			// scan address
			if (in_acc) begin
				rd_ptr_q <= '0;
			end else if (state_q == nons_pkg::S_SCAN && !scan_last) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			rd_vld_s1 <= (state_q == nons_pkg::S_SCAN);
			// best-so-far valid flag
			if (in_acc) begin
				found_q <= 1'b0;
			end else if (rd_vld_s1 && take) begin
				found_q <= 1'b1;
			end
			// output register handshake
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// query payload and best candidate
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= in_mode;
			qkey_q <= $signed(s_tdata);
		end
		if (rd_vld_s1 && take) begin
			best_key_q <= rd_data_s1;
			best_idx_q <= rd_idx_s1;
		end
		if (out_load) begin
			node_q   <= res_idx_x[NIW-1:0];
			status_q <= res_status;
		end
	end

	// final answer: found, fallback to last or first entry, or empty table
	always_comb begin
		priority if (count_q == '0) begin
			res_idx    = '0;
			res_status = nons_pkg::ST_EMPTY;
		end else if (found_q) begin
			res_idx    = best_idx_q;
			res_status = nons_pkg::ST_FOUND;
		end else if (mode_q == nons_pkg::MODE_NEXT) begin
			res_idx    = cnt_m1[AW-1:0];
			res_status = nons_pkg::ST_FALLBACK;
		end else begin
			res_idx    = '0;
			res_status = nons_pkg::ST_FALLBACK;
		end
	end

	// index goes out masked or zero-padded to the node index width
	assign res_idx_x = XW'(res_idx);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OTW'(node_q);
	assign m_tuser  = status_q;

	`NONS_ASSERT(a_count_bound, count_q <= CW'(MAX_ENTRIES), "entry count past capacity")
	`NONS_ASSERT(a_scan_in_table, (state_q == nons_pkg::S_SCAN) |-> (CW'(rd_ptr_q) < count_q), "scan read beyond filled entries")
	`NONS_ASSERT(a_best_order, (found_q && (state_q == nons_pkg::S_FINISH)) |-> (((mode_q == nons_pkg::MODE_NEXT) && (best_key_q > qkey_q)) || ((mode_q == nons_pkg::MODE_PREV) && (best_key_q < qkey_q))), "best key on wrong side of query")
	`NONS_ASSERT(a_result_from_finish, $rose(m_tvalid_q) |-> $past(state_q == nons_pkg::S_FINISH), "result raised outside finish")

endmodule
